// ===== hw/rtl/ntaf_pkg.sv =====
// Shared types, constants and helpers for the number to ASCII formatter.
package ntaf_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int DIGIT_BITS     = 4;
  localparam int NUM_DIGITS     = 10;
  localparam int BCD_BITS       = DIGIT_BITS * NUM_DIGITS;
  localparam int IDX_BITS       = $clog2(NUM_DIGITS);

  localparam logic [1:0] ACT_DEC  = 2'd0;
  localparam logic [1:0] ACT_HEX  = 2'd1;
  localparam logic [1:0] ACT_TIME = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_A    = 8'h41;  // 'A'

  typedef struct packed {
    logic [1:0]            action;
    logic [FIELD_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                  hex;
    logic                  pad;
    logic [FIELD_BITS-1:0] value;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [DIGIT_BITS-1:0] d);
    logic [7:0] c;
    if (d < 4'hA) begin
      c = CHAR_ZERO + {4'h0, d};
    end else begin
      c = CHAR_A + {4'h0, d} - 8'h0A;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ntaf_front.sv =====
// Front end: accepts items, classifies the format and queues commands.
module ntaf_front #(
  parameter int VALUE_BITS = ntaf_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntaf_pkg::in_item_t in_item_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output ntaf_pkg::cmd_t     cmd_o
);
  import ntaf_pkg::*;

  localparam int CONV_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    cmd_new.hex   = (in_item_i.action == ACT_HEX);
    cmd_new.pad   = (in_item_i.action == ACT_TIME);
    // value taken modulo 2^CONV_BITS
    cmd_new.value = FIELD_BITS'(in_item_i.value[CONV_BITS-1:0]);
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 2'd1) else $error("push lost");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 2'd1) else $error("pop lost");

endmodule

// ===== hw/rtl/ntaf_back.sv =====
// Back end: binary to BCD conversion for decimal/time and digit emission with zero suppression.
module ntaf_back #(
  parameter int VALUE_BITS = ntaf_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  ntaf_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ntaf_pkg::out_item_t out_item_o
);
  import ntaf_pkg::*;

  localparam int CONV_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int CNT_BITS  = $clog2(CONV_BITS + 1);
  localparam logic [IDX_BITS-1:0] TOP_IDX = IDX_BITS'(NUM_DIGITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_e;

  state_e                state_q, state_d;
  logic [BCD_BITS-1:0]   digits_q, digits_d;
  logic [CONV_BITS-1:0]  bin_q, bin_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic                  started_q, started_d;
  logic                  pad_q, pad_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  logic [BCD_BITS-1:0]   adjusted;
  logic [DIGIT_BITS-1:0] cur_digit;
  logic                  slot_free;
  logic                  emit;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign cur_digit   = digits_q[{idx_q, 2'b00} +: DIGIT_BITS];
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // add-3 correction on every BCD digit before each shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adjusted[i*DIGIT_BITS +: DIGIT_BITS] =
        (digits_q[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) ?
        digits_q[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3 :
        digits_q[i*DIGIT_BITS +: DIGIT_BITS];
    end
  end

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    bin_d       = bin_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    started_d   = started_q;
    pad_d       = pad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    emit        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          idx_d     = TOP_IDX;
          started_d = 1'b0;
          pad_d     = cmd_i.pad && !cmd_i.hex;
          bin_d     = cmd_i.value[CONV_BITS-1:0];
          cnt_d     = CNT_BITS'(CONV_BITS);
          if (cmd_i.hex) begin
            digits_d = BCD_BITS'(cmd_i.value[CONV_BITS-1:0]);
            state_d  = ST_EMIT;
          end else begin
            digits_d = '0;
            state_d  = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        digits_d = {adjusted[BCD_BITS-2:0], bin_q[CONV_BITS-1]};
        bin_d    = bin_q << 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_q && cur_digit == '0 && idx_q != '0) begin
          idx_d = idx_q - 1'b1;  // leading zero, skip
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          if (!started_q && pad_q && idx_q == '0) begin
            // single digit in time mode: extra leading zero
            out_d.char_code = CHAR_ZERO;
            out_d.last_char = 1'b0;
            pad_d           = 1'b0;
          end else begin
            emit            = 1'b1;
            out_d.char_code = hex_char(cur_digit);
            out_d.last_char = (idx_q == '0);
            started_d       = 1'b1;
            if (idx_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      pad_q       <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      pad_q       <= pad_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    bin_q    <= bin_d;
    out_q    <= out_d;
  end

  a_conv_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> cnt_q != '0) else $error("conversion count underflow");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_d.last_char) |=> state_q == ST_IDLE) else $error("last char not final");
  a_hex_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cmd_valid_i && cmd_i.hex) |=> state_q == ST_EMIT)
    else $error("hex item entered conversion");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> idx_q <= TOP_IDX) else $error("digit index out of range");

endmodule

// ===== hw/rtl/number_to_ascii_formatter.sv =====
// Number to ASCII formatter: decimal, hex and time output (zero-padded to at least two digits).
// Decimal and time items pass through the bit-serial BCD shift loop; hex items go
//   straight to the 10-digit emit scan, which skips leading zeros, then emits one
//   char per cycle while out_ready_i holds. The back end takes a new item only after
//   the last char of the previous one has been emitted.
// A 2-entry command queue lets new items be accepted while one is emitted.
// Reset (async, active low) empties the queue and drops any pending output.
module number_to_ascii_formatter #(
  parameter int VALUE_BITS = ntaf_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ntaf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ntaf_pkg::out_item_t out_item_o
);
  import ntaf_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  ntaf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ntaf_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
